[src/rfe_pkg.sv]
// ----------------------------------------------------------------------------
// rfe_pkg: shared types and constants of the RGB5551 framebuffer engine
// Command codes, pixel field masks, color conversion and the command record.
// ----------------------------------------------------------------------------
package rfe_pkg;

  localparam int unsigned MaxDim   = 256;
  localparam int unsigned DimW     = 9;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned Words    = MaxDim * MaxDim;
  localparam int unsigned LinW     = 18;   // holds width*height and x + w*y
  localparam logic [15:0] StencilMask = 16'h8000;

  typedef enum logic [3:0] {
    REQ_FILL     = 4'd0,
    REQ_STN_RECT = 4'd1,
    REQ_SET_STN  = 4'd2,
    REQ_GET_STN  = 4'd3,
    REQ_SET_COL  = 4'd4,
    REQ_GET_COL  = 4'd5,
    REQ_KEY      = 4'd6,
    REQ_FLIPX    = 4'd7,
    REQ_FLIPY    = 4'd8
  } req_e;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    logic [3:0]      req;
    logic [DimW-1:0] xs;
    logic [DimW-1:0] ys;
    logic [DimW-1:0] xe;   // clipped
    logic [DimW-1:0] ye;   // clipped
    logic [LinW-1:0] idx;  // point linear index
    logic            oob;  // point linear index at or beyond width*height
    logic [14:0]     col;  // encoded color without stencil
    logic            solid;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       solid;
    logic       status;
  } res_t;

  // 5-bit channel to 8 bits: (v*2114)>>8
  function automatic logic [7:0] dec5(input logic [4:0] v);
    logic [16:0] p;
    p = 17'(v) * 17'd2114;
    return p[15:8];
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_WAIT, ST_WR, ST_WR2, ST_DONE
  } bst_e;

endpackage

[src/rgb5551_framebuffer_engine.sv]
// ----------------------------------------------------------------------------
// rgb5551_framebuffer_engine: 1-5-5-5 framebuffer command engine
// Top level: configuration registers, command front end and execution back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction; output channel (out_valid_o / out_stall_i) returns exactly
//   one result per command, in order. Configuration writes (cfg_we_i) set
//   width (index 0) and height (index 1); values above 256 store 256.
// Sequencing:
//   Point commands inside the image go from dequeue through read, registered
//   read data, write and result states. Rectangle and key commands read, wait
//   and write each pixel, with a row step per row; flips read and write both
//   pixels of a swapped pair, with a row step per row. The single port of the
//   64K-word pixel memory sets this order. A two-entry command queue lets new commands enter while one executes.
// Reset:
//   Width and height clear to zero; pixel memory content is undefined until
//   written. No clearing pass is run.
// Stall:
//   A pending result holds stable while out_stall_i is high and the back end
//   waits; the front queue keeps accepting until full.
// ----------------------------------------------------------------------------
module rgb5551_framebuffer_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] req_type_i,
  input  logic [8:0] x_start_i,
  input  logic [8:0] y_start_i,
  input  logic [8:0] x_end_i,
  input  logic [8:0] y_end_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic       solid_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic       solid_out_o,
  output logic       status_o
);
  import rfe_pkg::*;

  logic [8:0] width_q, height_q, cv;
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;
  res_t       res;

  // configuration registers, saturated at the maximum dimension
  assign cv = (cfg_data_i > 9'(MaxDim)) ? 9'(MaxDim) : cfg_data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0; height_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgWidth) width_q <= cv;
      else                         height_q <= cv;
    end
  end

  rfe_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i,
    .x_start_i, .y_start_i, .x_end_i, .y_end_i,
    .red_in_i, .green_in_i, .blue_in_i, .solid_in_i,
    .width_i(width_q), .height_i(height_q),
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  rfe_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .width_i(width_q), .height_i(height_q),
    .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign red_out_o   = res.red;
  assign green_out_o = res.green;
  assign blue_out_o  = res.blue;
  assign solid_out_o = res.solid;
  assign status_o    = res.status;

endmodule

[src/rfe_front.sv]
// ----------------------------------------------------------------------------
// rfe_front: command intake
// Accepts transactions, clips rectangles, computes point index and encodes color.
// ----------------------------------------------------------------------------
module rfe_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [3:0]              req_type_i,
  input  logic [8:0]              x_start_i,
  input  logic [8:0]              y_start_i,
  input  logic [8:0]              x_end_i,
  input  logic [8:0]              y_end_i,
  input  logic [7:0]              red_in_i,
  input  logic [7:0]              green_in_i,
  input  logic [7:0]              blue_in_i,
  input  logic                    solid_in_i,
  input  logic [8:0]              width_i,
  input  logic [8:0]              height_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_pop_i,
  output rfe_pkg::cmd_t           cmd_o
);
  import rfe_pkg::*;

  // two-entry queue
  cmd_t        fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  cmd_t        c;
  logic [17:0] wy, tot;
  logic        push;

  always_comb begin
    wy  = 18'(width_i) * 18'(y_start_i);
    tot = 18'(width_i) * 18'(height_i);
    c.req   = req_type_i;
    c.xs    = x_start_i;
    c.ys    = y_start_i;
    c.xe    = (x_end_i > width_i) ? width_i : x_end_i;
    c.ye    = (y_end_i > height_i) ? height_i : y_end_i;
    c.idx   = wy + 18'(x_start_i);
    c.oob   = (wy + 18'(x_start_i)) >= tot;
    c.col   = {blue_in_i[7:3], green_in_i[7:3], red_in_i[7:3]};
    c.solid = solid_in_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= c;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop from empty queue");
  no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue overflow");
  full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> in_stall_o) else $error("full queue not stalling");

endmodule

[src/rfe_back.sv]
// ----------------------------------------------------------------------------
// rfe_back: command execution
// Walks pixels of the pixel memory, never reading and writing it in the same cycle.
// ----------------------------------------------------------------------------
module rfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  rfe_pkg::cmd_t  cmd_i,
  input  logic [8:0]     width_i,
  input  logic [8:0]     height_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rfe_pkg::res_t  res_o
);
  import rfe_pkg::*;

  logic [15:0] mem [Words];
  logic [15:0] rdata_q;

  bst_e        st_q, st_d;
  cmd_t        cmd_q;
  logic [8:0]  x_q, x_d, y_q, y_d;
  logic [15:0] t_q, t_d;
  res_t        res_q, res_d;
  logic        load;

  logic [17:0] lin_a, lin_b, raddr, waddr;
  logic        rd_en, wr_en;
  logic [15:0] wdata;
  logic [8:0]  xlim, ylim, xb, yb, x0;
  logic        is_rect, is_pt, is_flip, is_key;

  assign is_rect = cmd_q.req == REQ_FILL || cmd_q.req == REQ_STN_RECT;
  assign is_pt   = cmd_q.req == REQ_SET_STN || cmd_q.req == REQ_GET_STN ||
                   cmd_q.req == REQ_SET_COL || cmd_q.req == REQ_GET_COL;
  assign is_key  = cmd_q.req == REQ_KEY;
  assign is_flip = cmd_q.req == REQ_FLIPX || cmd_q.req == REQ_FLIPY;

  // walk bounds per command class
  always_comb begin
    x0 = is_rect ? cmd_q.xs : 9'd0;
    unique case (1'b1)
      is_rect: begin xlim = cmd_q.xe; ylim = cmd_q.ye; end
      cmd_q.req == REQ_FLIPX: begin xlim = width_i >> 1; ylim = height_i; end
      cmd_q.req == REQ_FLIPY: begin xlim = width_i; ylim = height_i >> 1; end
      default: begin xlim = width_i; ylim = height_i; end
    endcase
    xb = (cmd_q.req == REQ_FLIPX) ? (width_i - 9'd1 - x_q) : x_q;
    yb = (cmd_q.req == REQ_FLIPY) ? (height_i - 9'd1 - y_q) : y_q;
    lin_a = 18'(y_q) * 18'(width_i) + 18'(x_q);
    lin_b = 18'(yb) * 18'(width_i) + 18'(xb);
  end

  assign load      = cmd_valid_i && (st_q == ST_IDLE);
  assign cmd_pop_o = load;

  // sequencer
  always_comb begin
    st_d = st_q; x_d = x_q; y_d = y_q; t_d = t_q; res_d = res_q;
    rd_en = 1'b0; wr_en = 1'b0; raddr = lin_a; waddr = lin_a; wdata = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          x_d = (cmd_i.req == REQ_FILL || cmd_i.req == REQ_STN_RECT) ? cmd_i.xs : 9'd0;
          y_d = (cmd_i.req == REQ_FILL || cmd_i.req == REQ_STN_RECT) ? cmd_i.ys : 9'd0;
          st_d = ST_RD;
        end
      end
      ST_RD: begin
        res_d = '0;
        if (is_pt) begin
          if (cmd_q.oob) begin
            res_d.status = 1'b1;
            st_d = ST_DONE;
          end else begin
            rd_en = 1'b1; raddr = cmd_q.idx; st_d = ST_WAIT;
          end
        end else if (is_rect || is_key || is_flip) begin
          if (y_q >= ylim || x0 >= xlim) begin
            st_d = ST_DONE;
          end else if (x_q >= xlim) begin
            x_d = x0; y_d = y_q + 9'd1;
          end else begin
            rd_en = 1'b1; raddr = lin_a; st_d = ST_WAIT;
          end
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_WAIT: begin
        t_d = rdata_q;
        if (is_flip) begin
          rd_en = 1'b1; raddr = lin_b; st_d = ST_WR;
        end else begin
          st_d = ST_WR;
        end
      end
      ST_WR: begin
        st_d = ST_RD;
        unique case (cmd_q.req)
          REQ_FILL: begin wr_en = 1'b1; wdata = {cmd_q.solid, cmd_q.col}; end
          REQ_STN_RECT: begin
            wr_en = 1'b1; wdata = {cmd_q.solid, t_q[14:0]};
          end
          REQ_KEY: begin
            wr_en = (t_q == {1'b1, cmd_q.col}); wdata = {1'b0, cmd_q.col};
          end
          REQ_FLIPX, REQ_FLIPY: begin
            wr_en = 1'b1; wdata = rdata_q; st_d = ST_WR2;
          end
          REQ_SET_STN: begin
            wr_en = 1'b1; waddr = cmd_q.idx; wdata = {cmd_q.solid, t_q[14:0]};
            st_d = ST_DONE;
          end
          REQ_SET_COL: begin
            wr_en = 1'b1; waddr = cmd_q.idx; wdata = {cmd_q.solid, cmd_q.col};
            st_d = ST_DONE;
          end
          REQ_GET_STN: begin res_d.solid = t_q[15]; st_d = ST_DONE; end
          REQ_GET_COL: begin
            res_d.red = dec5(t_q[4:0]); res_d.green = dec5(t_q[9:5]);
            res_d.blue = dec5(t_q[14:10]); res_d.solid = t_q[15];
            st_d = ST_DONE;
          end
          default: st_d = ST_DONE;
        endcase
        if (is_rect || is_key) x_d = x_q + 9'd1;
      end
      ST_WR2: begin
        wr_en = 1'b1; waddr = lin_b; wdata = t_q;
        x_d = x_q + 9'd1; st_d = ST_RD;
      end
      ST_DONE: begin
        if (!out_stall_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // pixel memory, one port used per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr[AddrW-1:0]] <= wdata;
    if (rd_en) rdata_q <= mem[raddr[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (load) cmd_q <= cmd_i;
    x_q <= x_d; y_q <= y_d; t_q <= t_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else         st_q <= st_d;
  end

  assign out_valid_o = (st_q == ST_DONE);
  assign res_o       = res_q;

  no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en)) else $error("memory port conflict");
  hold_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_o)))
    else $error("result dropped under stall");
  pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (st_q == ST_RD)) else $error("pop without start");

endmodule
